>>> hw/rtl/page_replacement_nru_aging_macros.svh
// assertion macros used by the page replacement top level
`ifndef PAGE_REPLACEMENT_NRU_AGING_MACROS_SVH
`define PAGE_REPLACEMENT_NRU_AGING_MACROS_SVH

// same-cycle implication
`define PRNA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PRNA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/prna_pkg.sv
// types and constants for the page replacement block
package prna_pkg;

   localparam int PAGE_W     = 5;
   localparam int FRAME_W    = 4;
   localparam int AGE_W      = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;
   localparam int NUM_CLASS  = 3;

   localparam logic [AGE_W-1:0] AGE_TOP = 8'd128;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES = 1'd1;

   localparam logic POLICY_NRU   = 1'b0;
   localparam logic POLICY_AGING = 1'b1;

   localparam logic [CSR_DATA_W-1:0] FRAMES_RESET = 5'd16;

   typedef struct packed {
      logic [PAGE_W-1:0] page;
      logic              is_write;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [FRAME_W-1:0] frame;
      logic               evicted;
      logic [PAGE_W-1:0]  evicted_page;
   } rsp_type;

   typedef struct packed {
      logic             ref_b;
      logic             mod_b;
      logic [AGE_W-1:0] age;
   } pstate_type;

   typedef struct packed {
      logic              vld;
      logic [PAGE_W-1:0] page;
      pstate_type        st;
   } scan_type;

   typedef struct packed {
      logic              write;
      logic [PAGE_W-1:0] page;
      pstate_type        st;
   } victim_type;

endpackage

>>> hw/rtl/page_replacement_nru_aging.sv
// top level: page replacement with nru and aging policies
//
//  channel | dir | handshake            | payload
//  req     | in  | req_valid/req_ready  | req_data (page, is_write)
//  rsp     | out | rsp_valid/rsp_ready  | rsp_data (hit, frame, evicted, evicted_page)
//  csr     | in  | csr_wr_en            | csr_index, csr_wr_data
//
// one reference at a time; n active frames, pages = min(PAGE_COUNT, 32)
// fetch, scan of n frames, decide, victim write, then nru page write or aging pass, done
// the single read port of the frame table and page-state memories sets the pace
// a page of zero or at or above PAGE_COUNT goes straight to done and returns a zero result
// synchronous reset empties all frames and page state through valid bits, no sweep
// ready again the cycle after the result is loaded, even while it waits in the output register
`include "page_replacement_nru_aging_macros.svh"

module page_replacement_nru_aging #(
   parameter int FRAME_COUNT = 16,
   parameter int PAGE_COUNT  = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  prna_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output prna_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [prna_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [prna_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   localparam int PAGE_DEPTH = (PAGE_COUNT < (1 << prna_pkg::PAGE_W)) ?
                               PAGE_COUNT : (1 << prna_pkg::PAGE_W);
   localparam int PIDX_W = $clog2(PAGE_DEPTH);
   localparam int FIDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
   localparam int CNT_W  = $clog2(FRAME_COUNT + 1);
   localparam int ACNT_W = $clog2(PAGE_DEPTH + 1);
   localparam int PST_W  = $bits(prna_pkg::pstate_type);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_FETCH  = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_VIC    = 3'd4;
   localparam logic [2:0] S_CUR    = 3'd5;
   localparam logic [2:0] S_AGE    = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0]                        state_ff, state_in;
   logic                              policy_ff, policy_in;
   logic [prna_pkg::CSR_DATA_W-1:0]   frames_ff, frames_in;
   logic [prna_pkg::PAGE_W-1:0]       cur_page_ff, cur_page_in;
   logic                              cur_wr_ff, cur_wr_in;
   prna_pkg::pstate_type              cur_st_ff, cur_st_in;
   logic [CNT_W-1:0]                  n_ff, n_in;
   logic [CNT_W-1:0]                  sc_ff, sc_in;
   logic                              p1_vld_ff, p1_vld_in;
   logic [FIDX_W-1:0]                 p1_idx_ff, p1_idx_in;
   logic                              p2_vld_ff, p2_vld_in;
   logic [FIDX_W-1:0]                 p2_idx_ff, p2_idx_in;
   logic [prna_pkg::PAGE_W-1:0]       p2_page_ff, p2_page_in;
   logic                              hit_fnd_ff, hit_fnd_in;
   logic [FIDX_W-1:0]                 hit_idx_ff, hit_idx_in;
   logic                              free_fnd_ff, free_fnd_in;
   logic [FIDX_W-1:0]                 free_idx_ff, free_idx_in;
   logic [PAGE_DEPTH-1:0]             seen_ff, seen_in;
   logic [PAGE_DEPTH-1:0]             twice_ff, twice_in;
   logic [FRAME_COUNT-1:0]            fval_ff, fval_in;
   logic [PAGE_DEPTH-1:0]             pval_ff, pval_in;
   logic                              frv_ff, frv_in;
   logic                              prv_ff, prv_in;
   prna_pkg::rsp_type                 res_ff, res_in;
   prna_pkg::victim_type              vic_ff, vic_in;
   logic                              vic_we_ff, vic_we_in;
   logic [ACNT_W-1:0]                 acnt_ff, acnt_in;
   logic                              a1_vld_ff, a1_vld_in;
   logic [PIDX_W-1:0]                 a1_page_ff, a1_page_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   prna_pkg::rsp_type                 rsp_data_ff, rsp_data_in;

   logic                              frm_we;
   logic [FIDX_W-1:0]                 frm_waddr;
   logic [prna_pkg::PAGE_W-1:0]       frm_wdata;
   logic [FIDX_W-1:0]                 frm_raddr;
   logic [prna_pkg::PAGE_W-1:0]       frm_rdata;
   logic                              pg_we;
   logic [PIDX_W-1:0]                 pg_waddr;
   prna_pkg::pstate_type              pg_wdata;
   logic [PIDX_W-1:0]                 pg_raddr;
   prna_pkg::pstate_type              pg_rdata;

   logic [prna_pkg::PAGE_W-1:0]       f_page;
   logic [PIDX_W-1:0]                 f_idx;
   logic [PIDX_W-1:0]                 cur_idx;
   logic [PIDX_W-1:0]                 vpg_idx;
   logic [PIDX_W-1:0]                 acnt_idx;
   prna_pkg::pstate_type              pg_eff;
   logic [CNT_W-1:0]                  act_n;
   logic                              page_ok;
   prna_pkg::scan_type                beat;
   logic [FIDX_W-1:0]                 vic_idx;
   prna_pkg::victim_type              vic_info;

   prna_ram #(
      .WIDTH (prna_pkg::PAGE_W),
      .DEPTH (FRAME_COUNT)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (frm_we),
      .wr_addr (frm_waddr),
      .wr_data (frm_wdata),
      .rd_addr (frm_raddr),
      .rd_data (frm_rdata)
   );

   prna_ram #(
      .WIDTH (PST_W),
      .DEPTH (PAGE_DEPTH)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (pg_we),
      .wr_addr (pg_waddr),
      .wr_data (pg_wdata),
      .rd_addr (pg_raddr),
      .rd_data (pg_rdata)
   );

   // unwritten entries read as empty / cleared
   assign f_page   = frv_ff ? frm_rdata : '0;
   assign pg_eff   = prv_ff ? pg_rdata : '0;
   assign f_idx    = f_page[PIDX_W-1:0];
   assign cur_idx  = cur_page_ff[PIDX_W-1:0];
   assign vpg_idx  = vic_info.page[PIDX_W-1:0];
   assign acnt_idx = acnt_ff[PIDX_W-1:0];

   assign beat.vld  = p2_vld_ff;
   assign beat.page = p2_page_ff;
   assign beat.st   = pg_eff;

   prna_victim #(
      .FIDX_W (FIDX_W)
   ) u_victim (
      .clock    (clock),
      .reset    (reset),
      .clear    (state_ff == S_FETCH),
      .policy   (policy_ff),
      .beat     (beat),
      .beat_idx (p2_idx_ff),
      .vic_idx  (vic_idx),
      .vic      (vic_info)
   );

   always_comb begin
      if (frames_ff == '0) begin
         act_n = CNT_W'(1);
      end else if (int'(frames_ff) > FRAME_COUNT) begin
         act_n = CNT_W'(FRAME_COUNT);
      end else begin
         act_n = CNT_W'(frames_ff);
      end
   end

   assign page_ok = (req_data.page != '0) && (int'(req_data.page) < PAGE_COUNT);

   always_comb begin
      state_in     = state_ff;
      policy_in    = policy_ff;
      frames_in    = frames_ff;
      cur_page_in  = cur_page_ff;
      cur_wr_in    = cur_wr_ff;
      cur_st_in    = cur_st_ff;
      n_in         = n_ff;
      sc_in        = sc_ff;
      p1_vld_in    = 1'b0;
      p1_idx_in    = p1_idx_ff;
      p2_vld_in    = 1'b0;
      p2_idx_in    = p2_idx_ff;
      p2_page_in   = p2_page_ff;
      hit_fnd_in   = hit_fnd_ff;
      hit_idx_in   = hit_idx_ff;
      free_fnd_in  = free_fnd_ff;
      free_idx_in  = free_idx_ff;
      seen_in      = seen_ff;
      twice_in     = twice_ff;
      fval_in      = fval_ff;
      pval_in      = pval_ff;
      res_in       = res_ff;
      vic_in       = vic_ff;
      vic_we_in    = vic_we_ff;
      acnt_in      = acnt_ff;
      a1_vld_in    = 1'b0;
      a1_page_in   = a1_page_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      frm_we    = 1'b0;
      frm_waddr = free_idx_ff;
      frm_wdata = cur_page_ff;
      frm_raddr = sc_ff[FIDX_W-1:0];
      pg_we     = 1'b0;
      pg_waddr  = cur_idx;
      pg_wdata  = cur_st_ff;
      pg_raddr  = req_data.page[PIDX_W-1:0];

      if (csr_wr_en) begin
         unique case (csr_index)
            prna_pkg::CSR_POLICY: policy_in = csr_wr_data[0];
            prna_pkg::CSR_FRAMES: frames_in = csr_wr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cur_page_in = req_data.page;
               cur_wr_in   = req_data.is_write;
               n_in        = act_n;
               if (page_ok) begin
                  state_in = S_FETCH;
               end else begin
                  res_in   = '0;
                  state_in = S_DONE;
               end
            end
         end
         S_FETCH: begin
            // page state of the referenced page arrives here
            cur_st_in   = pg_eff;
            sc_in       = '0;
            hit_fnd_in  = 1'b0;
            free_fnd_in = 1'b0;
            seen_in     = '0;
            twice_in    = '0;
            state_in    = S_SCAN;
         end
         S_SCAN: begin
            if (sc_ff < n_ff) begin
               p1_vld_in = 1'b1;
               p1_idx_in = sc_ff[FIDX_W-1:0];
               sc_in     = sc_ff + CNT_W'(1);
            end
            // frame entry is back: look up its page state next
            p2_vld_in  = p1_vld_ff;
            p2_idx_in  = p1_idx_ff;
            p2_page_in = f_page;
            pg_raddr   = f_idx;
            if (p1_vld_ff) begin
               if (!hit_fnd_ff && (f_page == cur_page_ff)) begin
                  hit_fnd_in = 1'b1;
                  hit_idx_in = p1_idx_ff;
               end
               if (!free_fnd_ff && (f_page == '0)) begin
                  free_fnd_in = 1'b1;
                  free_idx_in = p1_idx_ff;
               end
               if (f_page != '0) begin
                  if (seen_ff[f_idx]) begin
                     twice_in[f_idx] = 1'b1;
                  end
                  seen_in[f_idx] = 1'b1;
               end
            end
            if ((sc_ff == n_ff) && !p1_vld_ff && !p2_vld_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            res_in    = '0;
            vic_we_in = 1'b0;
            if (hit_fnd_ff) begin
               res_in.hit   = 1'b1;
               res_in.frame = prna_pkg::FRAME_W'(hit_idx_ff);
            end else begin
               frm_we = 1'b1;
               if (free_fnd_ff) begin
                  frm_waddr    = free_idx_ff;
                  res_in.frame = prna_pkg::FRAME_W'(free_idx_ff);
               end else begin
                  frm_waddr           = vic_idx;
                  res_in.frame        = prna_pkg::FRAME_W'(vic_idx);
                  res_in.evicted      = 1'b1;
                  res_in.evicted_page = vic_info.page;
                  vic_in              = vic_info;
                  vic_we_in           = vic_info.write;
                  // victim stays resident only if another active frame holds it
                  if (!twice_ff[vpg_idx]) begin
                     seen_in[vpg_idx] = 1'b0;
                  end
               end
            end
            seen_in[cur_idx] = 1'b1;
            state_in = S_VIC;
         end
         S_VIC: begin
            if (vic_we_ff) begin
               pg_we    = 1'b1;
               pg_waddr = vic_ff.page[PIDX_W-1:0];
               pg_wdata = vic_ff.st;
            end
            state_in = S_CUR;
         end
         S_CUR: begin
            if (policy_ff == prna_pkg::POLICY_NRU) begin
               pg_we    = 1'b1;
               pg_waddr = cur_idx;
               if (res_ff.hit) begin
                  pg_wdata = cur_st_ff;
                  if (cur_wr_ff) begin
                     pg_wdata.mod_b = 1'b1;
                  end else begin
                     pg_wdata.ref_b = 1'b1;
                  end
               end else begin
                  pg_wdata.ref_b = !cur_wr_ff;
                  pg_wdata.mod_b = cur_wr_ff;
                  pg_wdata.age   = res_ff.evicted ? '0 : cur_st_ff.age;
               end
               state_in = S_DONE;
            end else begin
               acnt_in  = ACNT_W'(1);
               state_in = S_AGE;
            end
         end
         S_AGE: begin
            if (acnt_ff < ACNT_W'(PAGE_DEPTH)) begin
               pg_raddr   = acnt_idx;
               a1_vld_in  = seen_ff[acnt_idx];
               a1_page_in = acnt_idx;
               acnt_in    = acnt_ff + ACNT_W'(1);
            end
            // shift in the reference bit of each resident page
            if (a1_vld_ff) begin
               pg_we    = 1'b1;
               pg_waddr = a1_page_ff;
               pg_wdata.mod_b = pg_eff.mod_b;
               if (a1_page_ff == cur_idx) begin
                  pg_wdata.ref_b = 1'b1;
                  pg_wdata.age   = res_ff.evicted ? prna_pkg::AGE_TOP :
                                   {1'b1, pg_eff.age[prna_pkg::AGE_W-1:1]};
               end else begin
                  pg_wdata.ref_b = 1'b0;
                  pg_wdata.age   = {pg_eff.ref_b, pg_eff.age[prna_pkg::AGE_W-1:1]};
               end
            end
            if ((acnt_ff == ACNT_W'(PAGE_DEPTH)) && !a1_vld_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (frm_we) begin
         fval_in[frm_waddr] = 1'b1;
      end
      if (pg_we) begin
         pval_in[pg_waddr] = 1'b1;
      end
      frv_in = fval_ff[frm_raddr];
      prv_in = pval_ff[pg_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         policy_ff    <= prna_pkg::POLICY_NRU;
         frames_ff    <= prna_pkg::FRAMES_RESET;
         fval_ff      <= '0;
         pval_ff      <= '0;
         p1_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         a1_vld_ff    <= 1'b0;
         hit_fnd_ff   <= 1'b0;
         free_fnd_ff  <= 1'b0;
         vic_we_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         frames_ff    <= frames_in;
         fval_ff      <= fval_in;
         pval_ff      <= pval_in;
         p1_vld_ff    <= p1_vld_in;
         p2_vld_ff    <= p2_vld_in;
         a1_vld_ff    <= a1_vld_in;
         hit_fnd_ff   <= hit_fnd_in;
         free_fnd_ff  <= free_fnd_in;
         vic_we_ff    <= vic_we_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_page_ff <= cur_page_in;
      cur_wr_ff   <= cur_wr_in;
      cur_st_ff   <= cur_st_in;
      n_ff        <= n_in;
      sc_ff       <= sc_in;
      p1_idx_ff   <= p1_idx_in;
      p2_idx_ff   <= p2_idx_in;
      p2_page_ff  <= p2_page_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      seen_ff     <= seen_in;
      twice_ff    <= twice_in;
      frv_ff      <= frv_in;
      prv_ff      <= prv_in;
      res_ff      <= res_in;
      vic_ff      <= vic_in;
      acnt_ff     <= acnt_in;
      a1_page_ff  <= a1_page_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PRNA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready stayed high after an accepted beat")
   `PRNA_ASSERT_NOW(a_scan_drained, clock, reset, state_ff == S_DECIDE, !p1_vld_ff && !p2_vld_ff, "decision taken with scan beats in flight")
   `PRNA_ASSERT_NOW(a_age_in_pass, clock, reset, a1_vld_ff, state_ff == S_AGE, "aging write outside the aging pass")
   `PRNA_ASSERT_NOW(a_victim_on_evict, clock, reset, (state_ff == S_VIC) && vic_we_ff, res_ff.evicted, "victim update without an eviction")
   `PRNA_ASSERT_NOW(a_no_evict_page, clock, reset, rsp_valid && !rsp_data.evicted, rsp_data.evicted_page == '0, "evicted page reported without eviction")

endmodule

>>> hw/rtl/prna_ram.sv
// generic single-write, single-read ram with registered read data
module prna_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/prna_victim.sv
// victim tracker: nru class search and aging minimum over the frame scan
module prna_victim #(
   parameter int FIDX_W = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear,
   input  logic                  policy,
   input  prna_pkg::scan_type    beat,
   input  logic [FIDX_W-1:0]     beat_idx,
   output logic [FIDX_W-1:0]     vic_idx,
   output prna_pkg::victim_type  vic
);

   localparam int NC = prna_pkg::NUM_CLASS;
   localparam logic [prna_pkg::AGE_W:0] MinInit = {1'b1, {prna_pkg::AGE_W{1'b0}}};

   logic [NC-1:0]                 cls_fnd_ff, cls_fnd_in;
   logic [FIDX_W-1:0]             cls_idx_ff  [NC];
   logic [FIDX_W-1:0]             cls_idx_in  [NC];
   logic [prna_pkg::PAGE_W-1:0]   cls_page_ff [NC];
   logic [prna_pkg::PAGE_W-1:0]   cls_page_in [NC];
   logic [prna_pkg::AGE_W-1:0]    cls_age_ff  [NC];
   logic [prna_pkg::AGE_W-1:0]    cls_age_in  [NC];
   logic [NC-1:0]                 cls_hit;

   logic [prna_pkg::AGE_W:0]      min_val_ff, min_val_in;
   logic [FIDX_W-1:0]             min_idx_ff, min_idx_in;
   logic [prna_pkg::PAGE_W-1:0]   min_page_ff, min_page_in;
   logic                          min_mod_ff, min_mod_in;
   logic [prna_pkg::PAGE_W-1:0]   f0_page_ff, f0_page_in;

   // class order: r0m1, r1m0, r1m1
   assign cls_hit[0] = !beat.st.ref_b && beat.st.mod_b;
   assign cls_hit[1] = beat.st.ref_b && !beat.st.mod_b;
   assign cls_hit[2] = beat.st.ref_b && beat.st.mod_b;

   always_comb begin
      cls_fnd_in  = cls_fnd_ff;
      cls_idx_in  = cls_idx_ff;
      cls_page_in = cls_page_ff;
      cls_age_in  = cls_age_ff;
      min_val_in  = min_val_ff;
      min_idx_in  = min_idx_ff;
      min_page_in = min_page_ff;
      min_mod_in  = min_mod_ff;
      f0_page_in  = f0_page_ff;
      if (clear) begin
         cls_fnd_in = '0;
         min_val_in = MinInit;
      end else if (beat.vld) begin
         for (int c = 0; c < NC; c++) begin
            if (!cls_fnd_ff[c] && cls_hit[c] && (beat.page != '0)) begin
               cls_fnd_in[c]  = 1'b1;
               cls_idx_in[c]  = beat_idx;
               cls_page_in[c] = beat.page;
               cls_age_in[c]  = beat.st.age;
            end
         end
         // strict compare keeps the first frame holding the minimum
         if ({1'b0, beat.st.age} < min_val_ff) begin
            min_val_in  = {1'b0, beat.st.age};
            min_idx_in  = beat_idx;
            min_page_in = beat.page;
            min_mod_in  = beat.st.mod_b;
         end
         if (beat_idx == '0) begin
            f0_page_in = beat.page;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cls_fnd_ff <= '0;
         min_val_ff <= MinInit;
      end else begin
         cls_fnd_ff <= cls_fnd_in;
         min_val_ff <= min_val_in;
      end
   end

   always_ff @(posedge clock) begin
      cls_idx_ff  <= cls_idx_in;
      cls_page_ff <= cls_page_in;
      cls_age_ff  <= cls_age_in;
      min_idx_ff  <= min_idx_in;
      min_page_ff <= min_page_in;
      min_mod_ff  <= min_mod_in;
      f0_page_ff  <= f0_page_in;
   end

   always_comb begin
      vic_idx = '0;
      vic     = '0;
      if (policy == prna_pkg::POLICY_NRU) begin
         // no class present falls back to frame 0 without touching its bits
         vic.page = f0_page_ff;
         for (int c = NC - 1; c >= 0; c--) begin
            if (cls_fnd_ff[c]) begin
               vic_idx      = cls_idx_ff[c];
               vic.page     = cls_page_ff[c];
               vic.write    = 1'b1;
               vic.st.ref_b = 1'b0;
               vic.st.mod_b = 1'b0;
               vic.st.age   = cls_age_ff[c];
            end
         end
      end else begin
         vic_idx      = min_idx_ff;
         vic.page     = min_page_ff;
         vic.write    = (min_page_ff != '0);
         vic.st.ref_b = 1'b0;
         vic.st.mod_b = min_mod_ff;
         vic.st.age   = prna_pkg::AGE_TOP;
      end
   end

endmodule
